/* hw/rtl/pixel_plot_unit_defines.svh */
// Assertion macros for the pixel plot unit.
// Included by modules that check their own logic; needs a clock i_clk and reset i_rst_n.
`ifndef PIXEL_PLOT_UNIT_DEFINES_SVH
`define PIXEL_PLOT_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
// check that holds on every clock edge out of reset
`define PPU_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);
// check that cons holds in the cycle after ante
`define PPU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PPU_ASSERT(lbl, cond, msg)
`define PPU_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

/* hw/rtl/ppu_pkg.sv */
// Package for the pixel plot unit: word types, register indexes, fixed constants.
// No dependencies.
package ppu_pkg;

    // fixed field width and transparent fill color
    localparam int PIXEL_INDEX_W = 14;
    localparam logic [7:0] TRANSPARENT_FILL = 8'hFF;

    // input word kinds
    localparam logic KIND_PLOT    = 1'b0;
    localparam logic KIND_PAL_WR  = 1'b1;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_CAMERA_X     = 3'd0,
        REG_CAMERA_Y     = 3'd1,
        REG_CLIP_ENABLE  = 3'd2,
        REG_CLIP_X_RANGE = 3'd3,
        REG_CLIP_Y_RANGE = 3'd4,
        REG_FILL_PATTERN = 3'd5,
        REG_FILL_COLOR   = 3'd6
    } t_reg_idx;

    // input word
    typedef struct packed {
        logic               kind;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic [15:0]        color_code;
        logic [8:0]         palette_index;
        logic [15:0]        palette_word;
    } t_plot_word;

    // result word
    typedef struct packed {
        logic [PIXEL_INDEX_W-1:0] pixel_index;
        logic [15:0]              pixel_color;
    } t_pixel_word;

endpackage

/* hw/rtl/pixel_plot_unit.sv */
// Pixel plot unit top level: camera offset, clip, bounds, palette lookup, fill pattern.
// Depends on ppu_pkg and pixel_plot_unit_defines.svh.
//
//  channel   | ports                                     | handshake
//  ----------+-------------------------------------------+----------------------------
//  input     | i_start, o_busy, i_word                   | taken when start & !busy
//  result    | o_strobe, o_result                        | one cycle, no back-pressure
//  config    | psel, penable, pwrite, paddr, pwdata,     | APB, pready always high
//            | prdata, pready                            |
//
// One word per cycle, every cycle; o_busy stays low. A taken plot word first
// registers its palette memory read and its shifted position, then runs the
// tests and the y*width multiply into the output register. Palette writes
// take effect at the accept edge, so the next word already sees them. Reset
// clears the registers and the pipeline valids; the palette has no reset. The
// receiver cannot stall.
`include "pixel_plot_unit_defines.svh"

module pixel_plot_unit #(
    parameter int FRAME_WIDTH  = 128,
    parameter int FRAME_HEIGHT = 96,
    parameter int PALETTE_SIZE = 512
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input words
    input  logic                 i_start,
    output logic                 o_busy,
    input  ppu_pkg::t_plot_word  i_word,
    // result words
    output logic                 o_strobe,
    output ppu_pkg::t_pixel_word o_result,
    // configuration
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [4:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);
    import ppu_pkg::*;

    localparam int PAW = $clog2(PALETTE_SIZE);
    localparam int XW  = $clog2(FRAME_WIDTH);
    localparam int YW  = $clog2(FRAME_HEIGHT);
    localparam int PW  = (XW + YW + 2 > PIXEL_INDEX_W) ? XW + YW + 2 : PIXEL_INDEX_W;

    // configuration registers
    logic signed [15:0] r_camera_x;
    logic signed [15:0] r_camera_y;
    logic               r_clip_enable;
    logic [15:0]        r_clip_x_range;
    logic [15:0]        r_clip_y_range;
    logic [15:0]        r_fill_pattern;
    logic [7:0]         r_fill_color;

    t_reg_idx w_reg_idx;
    logic     w_cfg_wr;

    assign pready    = 1'b1;
    assign w_reg_idx = t_reg_idx'(paddr[4:2]);
    assign w_cfg_wr  = psel & penable & pwrite;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_camera_x     <= '0;
            r_camera_y     <= '0;
            r_clip_enable  <= 1'b0;
            r_clip_x_range <= '0;
            r_clip_y_range <= '0;
            r_fill_pattern <= '0;
            r_fill_color   <= '0;
        end else if (w_cfg_wr) begin
            unique case (w_reg_idx)
                REG_CAMERA_X:     r_camera_x     <= pwdata[15:0];
                REG_CAMERA_Y:     r_camera_y     <= pwdata[15:0];
                REG_CLIP_ENABLE:  r_clip_enable  <= pwdata[0];
                REG_CLIP_X_RANGE: r_clip_x_range <= pwdata[15:0];
                REG_CLIP_Y_RANGE: r_clip_y_range <= pwdata[15:0];
                REG_FILL_PATTERN: r_fill_pattern <= pwdata[15:0];
                REG_FILL_COLOR:   r_fill_color   <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // register reads
    always_comb begin
        unique case (w_reg_idx)
            REG_CAMERA_X:     prdata = {16'b0, r_camera_x};
            REG_CAMERA_Y:     prdata = {16'b0, r_camera_y};
            REG_CLIP_ENABLE:  prdata = {31'b0, r_clip_enable};
            REG_CLIP_X_RANGE: prdata = {16'b0, r_clip_x_range};
            REG_CLIP_Y_RANGE: prdata = {16'b0, r_clip_y_range};
            REG_FILL_PATTERN: prdata = {16'b0, r_fill_pattern};
            REG_FILL_COLOR:   prdata = {24'b0, r_fill_color};
            default:          prdata = '0;
        endcase
    end

    // accept
    logic w_accept, w_plot_acc, w_pal_wr, w_code_in_pal;

    assign o_busy        = 1'b0;
    assign w_accept      = i_start & ~o_busy;
    assign w_plot_acc    = w_accept & (i_word.kind == KIND_PLOT);
    assign w_pal_wr      = w_accept & (i_word.kind == KIND_PAL_WR)
                         & (32'(i_word.palette_index) < PALETTE_SIZE);
    assign w_code_in_pal = 32'(i_word.color_code) < PALETTE_SIZE;

    // palette memory, one write or one read per cycle
    logic [15:0] r_palette [PALETTE_SIZE];
    logic [15:0] r_pal_q;

    always_ff @(posedge i_clk) begin
        if (w_pal_wr) begin
            r_palette[PAW'(i_word.palette_index)] <= i_word.palette_word;
        end
        if (w_plot_acc && w_code_in_pal) begin
            r_pal_q <= r_palette[PAW'(i_word.color_code)];
        end
    end

    // stage 1: shifted position and color source
    logic               r_s1_valid;
    logic signed [16:0] r_s1_x;
    logic signed [16:0] r_s1_y;
    logic               r_s1_use_pal;
    logic [15:0]        r_s1_code;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= w_plot_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_plot_acc) begin
            r_s1_x       <= {i_word.pos_x[15], i_word.pos_x} - {r_camera_x[15], r_camera_x};
            r_s1_y       <= {i_word.pos_y[15], i_word.pos_y} - {r_camera_y[15], r_camera_y};
            r_s1_use_pal <= w_code_in_pal;
            r_s1_code    <= i_word.color_code;
        end
    end

    // stage 1 tests: clip window, frame bounds, fill pattern
    logic               w_clip_ok, w_frame_ok, w_pat_hit, w_keep;
    logic [3:0]         w_pat_bit;
    logic [15:0]        w_color;
    logic [PW-1:0]      w_index;

    always_comb begin
        w_clip_ok = !r_clip_enable ||
                    (r_s1_x >= $signed({9'b0, r_clip_x_range[7:0]}) &&
                     r_s1_x <= $signed({9'b0, r_clip_x_range[15:8]}) &&
                     r_s1_y >= $signed({9'b0, r_clip_y_range[7:0]}) &&
                     r_s1_y <= $signed({9'b0, r_clip_y_range[15:8]}));
        w_frame_ok = !r_s1_x[16] && (r_s1_x < $signed(17'(FRAME_WIDTH)))
                  && !r_s1_y[16] && (r_s1_y < $signed(17'(FRAME_HEIGHT)));
        // pattern bit 15 is the top-left cell, row major
        w_pat_bit = {r_s1_y[1:0], r_s1_x[1:0]};
        w_pat_hit = (r_fill_pattern != '0) && r_fill_pattern[4'd15 - w_pat_bit];
        w_keep    = w_clip_ok && w_frame_ok && !(w_pat_hit && r_fill_color == TRANSPARENT_FILL);
        if (w_pat_hit) begin
            w_color = {8'b0, r_fill_color};
        end else if (r_s1_use_pal) begin
            w_color = r_pal_q;
        end else begin
            w_color = r_s1_code;
        end
        w_index = PW'(r_s1_y[YW-1:0]) * PW'(FRAME_WIDTH) + PW'(r_s1_x[XW-1:0]);
    end

    // stage 2: output register
    logic        r_out_valid, n_out_valid;
    t_pixel_word r_out, n_out;

    assign n_out_valid       = r_s1_valid & w_keep;
    assign n_out.pixel_index = w_index[PIXEL_INDEX_W-1:0];
    assign n_out.pixel_color = w_color;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_out_valid) begin
            r_out <= n_out;
        end
    end

    assign o_strobe = r_out_valid;
    assign o_result = r_out;

    // checks
    `PPU_ASSERT(a_strobe_from_plot, !o_strobe || $past(w_plot_acc, 2), "strobe without plot")
    `PPU_ASSERT_NEXT(a_pal_wr_no_s1, w_accept && !w_plot_acc, !r_s1_valid, "write in plot path")
    `PPU_ASSERT_NEXT(a_drop_no_strobe, r_s1_valid && !w_keep, !o_strobe, "discard leaked")
    `PPU_ASSERT(a_index_in_frame, !o_strobe || (FRAME_WIDTH * FRAME_HEIGHT > 16384) ||
        (32'(o_result.pixel_index) < FRAME_WIDTH * FRAME_HEIGHT), "index out of frame")

endmodule

/* dv/pixel_plot_checker.sv */
// Checker for the pixel plot unit: follows the register port and the input channel,
// predicts every pixel word and compares it with what the block puts out.
// Depends on ppu_pkg.
module pixel_plot_checker #(
    parameter int FRAME_WIDTH  = 128,
    parameter int FRAME_HEIGHT = 96,
    parameter int PALETTE_SIZE = 512
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic                 i_busy,
    input  ppu_pkg::t_plot_word  i_word,
    input  logic                 i_strobe,
    input  ppu_pkg::t_pixel_word i_result,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [4:0]           paddr,
    input  logic [31:0]          pwdata,
    input  logic                 pready,
    output int                   o_errors,
    output int                   o_outstanding,
    output int                   o_pixels
);
    import ppu_pkg::*;

    // shadow copy of the registers and the palette
    logic signed [15:0] cam_x, cam_y;
    logic               clip_en;
    logic [15:0]        clip_xr, clip_yr, fill_pat;
    logic [7:0]         fill_col;
    logic [15:0]        pal_mem [PALETTE_SIZE];

    t_pixel_word pixel_q [$];
    int          err_cnt = 0;
    int          pix_cnt = 0;

    // pixel a plot word produces; returns 0 when it is clipped, off screen or masked
    function automatic bit predict_pixel(input t_plot_word w, output t_pixel_word px);
        int          x, y, x_lo, x_hi, y_lo, y_hi, sel;
        logic [15:0] color;
        logic [31:0] lin;
        px = '0;
        x = $signed(w.pos_x) - $signed(cam_x);
        y = $signed(w.pos_y) - $signed(cam_y);
        x_lo = clip_xr[7:0];
        x_hi = clip_xr[15:8];
        y_lo = clip_yr[7:0];
        y_hi = clip_yr[15:8];
        if (clip_en && (x < x_lo || x > x_hi || y < y_lo || y > y_hi)) return 1'b0;
        if (x < 0 || x >= FRAME_WIDTH || y < 0 || y >= FRAME_HEIGHT) return 1'b0;
        color = (w.color_code < PALETTE_SIZE) ? pal_mem[w.color_code[8:0]] : w.color_code;
        // dither mask, bit 15 is the top-left cell of the 4x4 tile
        if (fill_pat != 16'h0000) begin
            sel = (x % 4) + (y % 4) * 4;
            if (fill_pat[15 - sel]) begin
                if (fill_col == TRANSPARENT_FILL) return 1'b0;
                color = {8'h00, fill_col};
            end
        end
        lin = y * FRAME_WIDTH + x;
        px.pixel_index = lin[PIXEL_INDEX_W-1:0];
        px.pixel_color = color;
        return 1'b1;
    endfunction

    always @(posedge i_clk) begin
        t_pixel_word want;
        if (!i_rst_n) begin
            cam_x    = '0;
            cam_y    = '0;
            clip_en  = 1'b0;
            clip_xr  = '0;
            clip_yr  = '0;
            fill_pat = '0;
            fill_col = '0;
            pixel_q.delete();
        end else begin
            // result side first: nothing taken at this edge can show up at it
            if (i_strobe !== 1'b0) begin
                if (pixel_q.size() == 0) begin
                    $display("%0t unexpected pixel word: expected none, got index %0d color %h",
                             $time, i_result.pixel_index, i_result.pixel_color);
                    err_cnt++;
                end else begin
                    want = pixel_q.pop_front();
                    pix_cnt++;
                    if (i_result.pixel_index !== want.pixel_index) begin
                        $display("%0t pixel_index mismatch: expected %0d got %0d",
                                 $time, want.pixel_index, i_result.pixel_index);
                        err_cnt++;
                    end
                    if (i_result.pixel_color !== want.pixel_color) begin
                        $display("%0t pixel_color mismatch: expected %h got %h",
                                 $time, want.pixel_color, i_result.pixel_color);
                        err_cnt++;
                    end
                end
            end
            // register writes
            if (psel && penable && pwrite && pready) begin
                case (paddr[4:2])
                    REG_CAMERA_X:     cam_x    = pwdata[15:0];
                    REG_CAMERA_Y:     cam_y    = pwdata[15:0];
                    REG_CLIP_ENABLE:  clip_en  = pwdata[0];
                    REG_CLIP_X_RANGE: clip_xr  = pwdata[15:0];
                    REG_CLIP_Y_RANGE: clip_yr  = pwdata[15:0];
                    REG_FILL_PATTERN: fill_pat = pwdata[15:0];
                    REG_FILL_COLOR:   fill_col = pwdata[7:0];
                    default: ;
                endcase
            end
            // input words
            if (i_start && !i_busy) begin
                if (i_word.kind == KIND_PAL_WR) begin
                    if (i_word.palette_index < PALETTE_SIZE)
                        pal_mem[i_word.palette_index] = i_word.palette_word;
                end else if (predict_pixel(i_word, want)) begin
                    pixel_q.push_back(want);
                end
            end
        end
        o_errors      <= err_cnt;
        o_outstanding <= pixel_q.size();
        o_pixels      <= pix_cnt;
    end

endmodule

/* dv/testbench.sv */
// Top of the pixel plot unit bench: clock, reset, register programming and word stimulus.
// Depends on ppu_pkg, pixel_plot_unit and pixel_plot_checker.
module testbench;
    import ppu_pkg::*;

    localparam int         LIMIT_CYCLES = 100000;
    localparam int         DRAIN_CYCLES = 4;
    localparam int         IDLE_PCT     = 22;
    localparam logic [2:0] REG_UNUSED   = 3'd7;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    t_plot_word  word_in;
    logic        strobe;
    t_pixel_word pixel_out;
    logic        psel, penable, pwrite, pready;
    logic [4:0]  paddr;
    logic [31:0] pwdata, prdata;

    int errors, outstanding, pixels;
    int cycle_cnt    = 0;
    int plots_sent   = 0;
    int pal_writes   = 0;
    int settings_cnt = 0;
    int idle_pct     = 0;

    // camera currently programmed, used to aim positions at the screen
    logic [15:0] cur_cam_x = '0;
    logic [15:0] cur_cam_y = '0;
    // palette entries written so far; only these may be looked up
    bit          pal_seen [512];
    int          pal_list [$];

    always #6 i_clk = ~i_clk;

    pixel_plot_unit dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .o_busy   (busy),
        .i_word   (word_in),
        .o_strobe (strobe),
        .o_result (pixel_out),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    pixel_plot_checker pixel_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_busy        (busy),
        .i_word        (word_in),
        .i_strobe      (strobe),
        .i_result      (pixel_out),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .o_errors      (errors),
        .o_outstanding (outstanding),
        .o_pixels      (pixels)
    );

    // run limit
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= LIMIT_CYCLES) begin
            $display("pixel_plot_unit regression: fail");
            $finish;
        end
    end

    // setup then access phase, then psel drops so writes never overlap
    task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic load_settings(input logic [15:0] cx, input logic [15:0] cy,
                                 input logic en, input logic [15:0] xr,
                                 input logic [15:0] yr, input logic [15:0] pat,
                                 input logic [7:0] fc);
        reg_write(REG_CAMERA_X, {16'h0000, cx});
        reg_write(REG_CAMERA_Y, {16'h0000, cy});
        reg_write(REG_CLIP_ENABLE, {31'h0, en});
        reg_write(REG_CLIP_X_RANGE, {16'h0000, xr});
        reg_write(REG_CLIP_Y_RANGE, {16'h0000, yr});
        reg_write(REG_FILL_PATTERN, {16'h0000, pat});
        reg_write(REG_FILL_COLOR, {24'h000000, fc});
        cur_cam_x = cx;
        cur_cam_y = cy;
        settings_cnt++;
    endtask

    // hand one word over, then maybe leave a gap
    task automatic send_word(input t_plot_word w);
        start   <= 1'b1;
        word_in <= w;
        do @(posedge i_clk); while (busy);
        if (w.kind == KIND_PAL_WR) pal_writes++;
        else plots_sent++;
        if ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge i_clk);
        end
    endtask

    // every field random; the caller overrides the ones that matter
    function automatic t_plot_word noise_word();
        t_plot_word w;
        w.kind          = 1'($urandom_range(1));
        w.pos_x         = 16'($urandom_range(65535));
        w.pos_y         = 16'($urandom_range(65535));
        w.color_code    = 16'($urandom_range(65535));
        w.palette_index = 9'($urandom_range(511));
        w.palette_word  = 16'($urandom_range(65535));
        return w;
    endfunction

    task automatic send_palette(input logic [8:0] idx, input logic [15:0] data);
        t_plot_word w;
        w = noise_word();
        w.kind          = KIND_PAL_WR;
        w.palette_index = idx;
        w.palette_word  = data;
        if (!pal_seen[idx]) begin
            pal_seen[idx] = 1'b1;
            pal_list.push_back(idx);
        end
        send_word(w);
    endtask

    task automatic send_plot(input logic [15:0] x, input logic [15:0] y,
                             input logic [15:0] code);
        t_plot_word w;
        w = noise_word();
        w.kind       = KIND_PLOT;
        w.pos_x      = x;
        w.pos_y      = y;
        w.color_code = code;
        send_word(w);
    endtask

    // mostly plots aimed around the visible area, some anywhere, some palette loads
    task automatic send_random();
        logic [15:0] px, py, code;
        int          ox, oy;
        if ($urandom_range(99) < 15) begin
            send_palette(9'($urandom_range(511)), 16'($urandom_range(65535)));
        end else begin
            if (pal_list.size() > 0 && $urandom_range(1) == 1)
                code = 16'(pal_list[$urandom_range(pal_list.size() - 1)]);
            else
                code = 16'($urandom_range(65535, 512));
            if ($urandom_range(99) < 85) begin
                ox = $urandom_range(139);
                oy = $urandom_range(107);
                px = cur_cam_x + 16'(ox - 6);
                py = cur_cam_y + 16'(oy - 6);
            end else begin
                px = 16'($urandom_range(65535));
                py = 16'($urandom_range(65535));
            end
            send_plot(px, py, code);
        end
    endtask

    task automatic run_random(input int n);
        repeat (n) send_random();
    endtask

    // stop sending until every pixel is out and the pipeline has emptied
    task automatic wait_idle();
        start <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        i_rst_n = 1'b0;
        start   = 1'b0;
        word_in = '0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed words at reset settings, back to back
        send_palette(9'd0, 16'hFFFF);
        send_palette(9'd511, 16'h8001);
        send_palette(9'h155, 16'h5AA5);
        send_plot(16'd0, 16'd0, 16'd0);
        send_plot(16'd127, 16'd95, 16'd511);
        send_plot(16'd128, 16'd0, 16'd0);          // just right of the screen
        send_plot(16'hFFFF, 16'd5, 16'd0);         // x of -1
        send_plot(16'd5, 16'd96, 16'd0);           // just below the screen
        send_plot(16'd5, 16'hFFFF, 16'd0);         // y of -1
        send_plot(16'h8000, 16'h7FFF, 16'hFFFF);
        send_plot(16'h7FFF, 16'h8000, 16'd512);
        send_plot(16'd64, 16'd48, 16'd512);        // first raw color code
        send_plot(16'd1, 16'd1, 16'hFFFF);
        send_palette(9'd0, 16'h1234);              // overwrite, read right after
        send_plot(16'd3, 16'd2, 16'd0);
        send_plot(16'd100, 16'd2, 16'h0155);
        send_palette(9'h0AA, 16'h0000);
        send_plot(16'd77, 16'd80, 16'h00AA);
        wait_idle();

        // clip window on, with one pause mid-stream until everything drains
        load_settings(16'd0, 16'd0, 1'b1, 16'h6410, 16'h5008, 16'h0000, 8'h00);
        idle_pct = IDLE_PCT;
        run_random(45);
        wait_idle();
        run_random(45);
        wait_idle();

        // extreme camera, dither with a solid fill color, no gaps at all
        load_settings(16'h8000, 16'hFFFA, 1'b0, 16'hFFFF, 16'h0000, 16'hA5A5, 8'h3C);
        idle_pct = 0;
        run_random(80);
        wait_idle();
        idle_pct = IDLE_PCT;

        // inverted clip window and a full transparent mask: nothing gets through
        load_settings(16'd20, 16'hFFEC, 1'b1, 16'h1020, 16'hFF00, 16'hFFFF, 8'hFF);
        run_random(50);
        wait_idle();

        // widest window, transparent top-left and bottom-right cells of the tile
        load_settings(16'd5, 16'hFFFD, 1'b1, 16'hFF00, 16'hFF00, 16'h8001, 8'hFF);
        run_random(80);
        wait_idle();

        // opposite camera extremes, plus a write to the unused address
        load_settings(16'h7FFF, 16'h8000, 1'b0, 16'h0000, 16'hFFFF, 16'h0000, 8'h00);
        reg_write(REG_UNUSED, $urandom);
        run_random(50);
        wait_idle();

        // random settings
        repeat (3) begin
            load_settings(16'($urandom_range(400) - 200), 16'($urandom_range(400) - 200),
                          1'($urandom_range(1)),
                          {8'($urandom_range(255, 20)), 8'($urandom_range(100))},
                          {8'($urandom_range(255, 20)), 8'($urandom_range(100))},
                          16'($urandom_range(65535)), 8'($urandom_range(255)));
            run_random(50);
            wait_idle();
        end

        $display("%0d plots and %0d palette loads sent, %0d pixel words checked",
                 plots_sent, pal_writes, pixels);
        $display("%0d register settings, with random gaps and one gap-free stretch",
                 settings_cnt);
        if (errors == 0) begin
            $display("pixel_plot_unit regression: pass");
        end else begin
            $display("pixel_plot_unit regression: fail");
        end
        $finish;
    end

endmodule
